// ===== hw/rtl/owhsr_pkg.sv =====
// ----------------------------------------------------------------------------
// owhsr_pkg: shared constants for the single-wire humidity sensor reader
// Widths of the receive path and timer, register indexes and reset values.
// ----------------------------------------------------------------------------
package owhsr_pkg;

  // receive path sizes
  localparam int DATA_BITS   = 32;  // 8 .. 32
  localparam int CHECK_BITS  = 8;
  localparam int TIMER_WIDTH = 16;  // 16 .. 24
  localparam int BIT_IDX_W   = 6;
  localparam int FRAME_BITS  = DATA_BITS + CHECK_BITS;

  // fixed pre-start high time in ticks
  localparam logic [TIMER_WIDTH:0] PRE_HIGH_TICKS = (TIMER_WIDTH + 1)'(4);

  // stream word widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELDS_W = 5 + 5 * 8;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = CFG_IDX_W'(3);

  localparam logic [15:0] START_LOW_RST    = 16'd25000;
  localparam logic [7:0]  RELEASE_RST      = 8'd60;
  localparam logic [7:0]  SETTLE_RST       = 8'd80;
  localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd32;

endpackage

// ===== hw/rtl/one_wire_humidity_sensor_reader_core.sv =====
// ----------------------------------------------------------------------------
// one_wire_humidity_sensor_reader_core: single-wire sensor read sequencer
// Runs the start pulse, answer check and 40-bit receive of a single-wire
// temperature and humidity sensor, one microsecond tick per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word on the s_axis channel is one microsecond tick carrying
//   the sampled line level and a start request. For every input word the
//   block returns one output word on m_axis describing that tick: line drive
//   controls, busy and done flags, the answer flag and the received bytes.
//   The tick work is a short state update between the accepted input word
//   and the output register, the only storage in the path, so each result
//   comes next cycle; throughput is one word per cycle while unstalled.
//   When the receiver stalls, the output word holds and s_axis_tready drops
//   until that word is taken; the result register frees in the same cycle it
//   is read, so words flow back to back.
//   Reset returns the sequencer to idle, clears the shift registers and loads
//   the default timing registers. The user writes timing registers through the
//   cfg port only while no sequence is running; the block does not enforce it.
// ----------------------------------------------------------------------------
module one_wire_humidity_sensor_reader_core
  import owhsr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // tick input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [0] start_request, [1] line_level, [7:2] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] drive_low, [1] drive_enable, [2] busy_res, [3] reading_done,
  // [4] sensor_answered, [12:5] humidity_int, [20:13] humidity_frac,
  // [28:21] temperature_int, [36:29] temperature_frac, [44:37] check_byte,
  // [47:45] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // sequencer phases
  localparam logic [3:0] PH_IDLE          = 4'd0;
  localparam logic [3:0] PH_PRE_HIGH      = 4'd1;
  localparam logic [3:0] PH_START_LOW     = 4'd2;
  localparam logic [3:0] PH_REL_HIGH      = 4'd3;
  localparam logic [3:0] PH_CHECK         = 4'd4;
  localparam logic [3:0] PH_WAIT_ANS_HIGH = 4'd5;
  localparam logic [3:0] PH_SETTLE        = 4'd6;
  localparam logic [3:0] PH_BIT_WAIT_LOW  = 4'd7;
  localparam logic [3:0] PH_BIT_WAIT_HIGH = 4'd8;
  localparam logic [3:0] PH_BIT_DELAY     = 4'd9;

  // timing registers
  logic [15:0] start_low_q;
  logic [7:0]  release_q;
  logic [7:0]  settle_q;
  logic [7:0]  sample_delay_q;

  // sequencer state
  logic [3:0]             phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] tick_q, tick_d;
  logic [BIT_IDX_W-1:0]   bit_idx_q, bit_idx_d;
  logic [DATA_BITS-1:0]   data_q, data_d;
  logic [CHECK_BITS-1:0]  check_q, check_d;

  // output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic in_accept;
  logic start_req;
  logic line_lvl;
  logic drv_en, drv_low, busy, done, answered;
  logic [TIMER_WIDTH-1:0] tick_cur;
  logic [TIMER_WIDTH:0]   tick_inc;
  logic [TIMER_WIDTH:0]   dur;
  logic [BIT_IDX_W-1:0]   bit_idx_inc;
  logic [31:0]            data_ext;
  logic [OUT_TDATA_W-1:0] out_word;

  assign start_req = s_axis_tdata[0];
  assign line_lvl  = s_axis_tdata[1];

  // output register frees in the cycle it is taken
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q    <= START_LOW_RST;
      release_q      <= RELEASE_RST;
      settle_q       <= SETTLE_RST;
      sample_delay_q <= SAMPLE_DELAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_LOW:    start_low_q    <= cfg_data_i[15:0];
        CFG_RELEASE:      release_q      <= cfg_data_i[7:0];
        CFG_SETTLE:       settle_q       <= cfg_data_i[7:0];
        CFG_SAMPLE_DELAY: sample_delay_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // per-tick sequencer step
  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_idx_d = bit_idx_q;
    data_d    = data_q;
    check_d   = check_q;
    drv_en    = 1'b0;
    drv_low   = 1'b0;
    busy      = 1'b0;
    done      = 1'b0;
    answered  = 1'b0;

    // a start request restarts from the pre-start high phase
    if (start_req) begin
      phase_d   = PH_PRE_HIGH;
      tick_d    = '0;
      bit_idx_d = '0;
      data_d    = '0;
      check_d   = '0;
    end

    tick_cur    = tick_d;
    tick_inc    = {1'b0, tick_cur} + (TIMER_WIDTH + 1)'(1);
    bit_idx_inc = bit_idx_d + BIT_IDX_W'(1);

    // duration of the current timed phase
    case (phase_d)
      PH_PRE_HIGH:  dur = PRE_HIGH_TICKS;
      PH_START_LOW: dur = (TIMER_WIDTH + 1)'(start_low_q);
      PH_REL_HIGH:  dur = (TIMER_WIDTH + 1)'(release_q);
      PH_SETTLE:    dur = (TIMER_WIDTH + 1)'(settle_q);
      default:      dur = (TIMER_WIDTH + 1)'(sample_delay_q);
    endcase

    case (phase_d)
      PH_IDLE: ;
      PH_PRE_HIGH, PH_START_LOW, PH_REL_HIGH: begin
        drv_en  = 1'b1;
        drv_low = (phase_d == PH_START_LOW);
        busy    = 1'b1;
        // driven phase ends on its last tick
        if (tick_inc >= dur) begin
          tick_d  = '0;
          phase_d = phase_d + 4'd1;
        end else begin
          tick_d = tick_inc[TIMER_WIDTH-1:0];
        end
      end
      PH_CHECK: begin
        if (!line_lvl) begin
          busy    = 1'b1;
          phase_d = PH_WAIT_ANS_HIGH;
        end else begin
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      PH_WAIT_ANS_HIGH: begin
        busy = 1'b1;
        if (line_lvl) begin
          tick_d  = '0;
          phase_d = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        busy = 1'b1;
        if ({1'b0, tick_cur} >= dur) begin
          tick_d  = '0;
          phase_d = PH_BIT_WAIT_LOW;
        end else begin
          tick_d = tick_inc[TIMER_WIDTH-1:0];
        end
      end
      PH_BIT_WAIT_LOW: begin
        busy = 1'b1;
        if (!line_lvl) phase_d = PH_BIT_WAIT_HIGH;
      end
      PH_BIT_WAIT_HIGH: begin
        busy = 1'b1;
        if (line_lvl) begin
          tick_d  = '0;
          phase_d = PH_BIT_DELAY;
        end
      end
      PH_BIT_DELAY: begin
        busy = 1'b1;
        if ({1'b0, tick_cur} >= dur) begin
          tick_d = '0;
          // sample and shift in, data bits first, msb first
          if (bit_idx_d < BIT_IDX_W'(DATA_BITS)) begin
            data_d = {data_d[DATA_BITS-2:0], line_lvl};
          end else begin
            check_d = {check_d[CHECK_BITS-2:0], line_lvl};
          end
          bit_idx_d = bit_idx_inc;
          if (bit_idx_inc >= BIT_IDX_W'(FRAME_BITS)) begin
            busy     = 1'b0;
            done     = 1'b1;
            answered = 1'b1;
            phase_d  = PH_IDLE;
          end else begin
            phase_d = PH_BIT_WAIT_LOW;
          end
        end else begin
          tick_d = tick_inc[TIMER_WIDTH-1:0];
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // result word packing
  assign data_ext = 32'(data_d);
  assign out_word = OUT_TDATA_W'({check_d[7:0], data_ext[7:0], data_ext[15:8],
                                  data_ext[23:16], data_ext[31:24],
                                  answered, done, busy, drv_en, drv_low});

  // sequencer state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      bit_idx_q <= '0;
      data_q    <= '0;
      check_q   <= '0;
    end else if (in_accept) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_idx_q <= bit_idx_d;
      data_q    <= data_d;
      check_q   <= check_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/owhsr_checker.sv =====
// ----------------------------------------------------------------------------
// owhsr_checker: port-level checks for the sensor reader core
// Watches the stream ports and flags flow or result word inconsistencies.
// ----------------------------------------------------------------------------
module owhsr_checker
  import owhsr_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // input side blocks only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input blocked without output stall");

  // every accepted tick yields a result word next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // finishing tick is never reported busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
    else $error("done and busy together");

  // line pulled low only while driven, answer only with done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[1]) &&
                      (!m_axis_tdata[4] || m_axis_tdata[3]))
    else $error("inconsistent drive or answer flags");

endmodule

bind one_wire_humidity_sensor_reader_core owhsr_checker u_owhsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
